// File: hw/rtl/lcd_seq_pkg.sv
// ---------------------------------------------------------------------------
// lcd_seq_pkg
// Types, codes and constants shared by the character LCD nibble sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcd_seq_pkg;

    // request codes
    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_CMD    = 3'd1;
    localparam logic [2:0] REQ_DATA   = 3'd2;
    localparam logic [2:0] REQ_CURSOR = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // hold times in ms
    localparam logic [1:0] HOLD_NONE   = 2'd0;
    localparam logic [1:0] HOLD_STROBE = 2'd1;
    localparam logic [1:0] HOLD_LONG   = 2'd2;

    localparam logic [7:0] CMD_FUNCSET = 8'h28;
    localparam logic [7:0] CMD_DISPON  = 8'h0C;
    localparam logic [7:0] CMD_ENTRY   = 8'h06;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [3:0] WAKE_NIB    = 4'h3;
    localparam logic [3:0] MODE4_NIB   = 4'h2;

    // nibble index of the last nibble of a request
    localparam logic [3:0] INIT_LAST_NIB = 4'd11;
    localparam logic [3:0] BYTE_LAST_NIB = 4'd1;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
        logic [3:0] column;
        logic       row;
    } lcd_req_t;

    typedef struct packed {
        logic [3:0] data_nibble;
        logic       reg_select;
        logic       enable_line;
        logic [1:0] hold_ms;
        logic       last;
    } lcd_snap_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_HI,
        ST_LO,
        ST_TAIL
    } lcd_state_t;

    typedef enum logic [1:0] {
        SNAP_PRE,
        SNAP_HI,
        SNAP_LO,
        SNAP_TAIL
    } snap_kind_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        snap_kind_t kind;
        logic [3:0] nib_idx;
        logic       use_table;
        logic       rs;
        logic [1:0] hold;
        logic       last;
    } lcd_cmd_t;

    typedef struct packed {
        logic out_free;
    } lcd_status_t;

    // wake-up nibbles followed by the four set-up commands
    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        unique case (idx) inside
            4'd0, 4'd1, 4'd2: nib = WAKE_NIB;
            4'd3:             nib = MODE4_NIB;
            4'd4:             nib = CMD_FUNCSET[7:4];
            4'd5:             nib = CMD_FUNCSET[3:0];
            4'd6:             nib = CMD_DISPON[7:4];
            4'd7:             nib = CMD_DISPON[3:0];
            4'd8:             nib = CMD_ENTRY[7:4];
            4'd9:             nib = CMD_ENTRY[3:0];
            4'd10:            nib = CMD_CLEAR[7:4];
            4'd11:            nib = CMD_CLEAR[3:0];
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lcd_seq_ctrl.sv
// ---------------------------------------------------------------------------
// lcd_seq_ctrl
// Controller: walks the snapshot sequence of one request and issues
// emit commands to the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcd_seq_ctrl
    import lcd_seq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic [2:0]  req_type,
    output logic             req_stall,
    input  wire lcd_status_t status,
    output lcd_cmd_t         cmd
);

    lcd_state_t state_reg, state_next;
    logic [2:0] type_reg, type_next;
    logic [3:0] nib_reg, nib_next;
    logic       final_nib;
    logic       is_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            type_reg  <= REQ_INIT;
            nib_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            type_reg  <= type_next;
            nib_reg   <= nib_next;
        end
    end

    assign is_data   = (type_reg == REQ_DATA);
    assign final_nib = (type_reg == REQ_INIT) ? (nib_reg == INIT_LAST_NIB)
                                              : (nib_reg == BYTE_LAST_NIB);
    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        type_next     = type_reg;
        nib_next      = nib_reg;
        cmd.load      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.kind      = SNAP_HI;
        cmd.nib_idx   = nib_reg;
        cmd.use_table = (type_reg == REQ_INIT);
        cmd.rs        = is_data;
        cmd.hold      = HOLD_STROBE;
        cmd.last      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load  = 1'b1;
                    type_next = req_type;
                    nib_next  = 4'd0;
                    unique case (req_type) inside
                        REQ_INIT, REQ_CMD, REQ_DATA, REQ_CLEAR: state_next = ST_HI;
                        REQ_CURSOR:                             state_next = ST_PRE;
                        default:                                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PRE:
            begin
                cmd.kind = SNAP_PRE;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_HI;
                end
            end
            ST_HI:
            begin
                cmd.kind = SNAP_HI;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                cmd.kind = SNAP_LO;
                cmd.last = final_nib && !is_data;
                if (final_nib && ((type_reg == REQ_CURSOR) || (type_reg == REQ_CLEAR)))
                begin
                    cmd.hold = HOLD_LONG;
                end
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!final_nib)
                    begin
                        nib_next   = nib_reg + 4'd1;
                        state_next = ST_HI;
                    end
                    else if (is_data)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                cmd.kind = SNAP_TAIL;
                cmd.rs   = 1'b0;
                cmd.hold = HOLD_NONE;
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/lcd_seq_dp.sv
// ---------------------------------------------------------------------------
// lcd_seq_dp
// Datapath: request byte, pin levels and the output snapshot register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcd_seq_dp
    import lcd_seq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lcd_req_t req,
    input  wire lcd_cmd_t cmd,
    output lcd_status_t   status,
    output logic          snap_valid,
    input  wire logic     snap_stall,
    output lcd_snap_t     snap
);

    logic [7:0] byte_reg, byte_next;
    logic [3:0] pin_nib_reg;
    logic       pin_rs_reg;
    logic       pin_en_reg;
    logic       valid_reg, valid_next;
    lcd_snap_t  snap_reg, snap_next;
    logic [3:0] nib_sel;

    // cursor address is 0x80 or 0xc0 plus the column
    always_comb
    begin
        unique case (req.req_type) inside
            REQ_CMD, REQ_DATA: byte_next = req.byte_value;
            REQ_CURSOR:        byte_next = {1'b1, req.row, 2'b00, req.column};
            REQ_CLEAR:         byte_next = CMD_CLEAR;
            default:           byte_next = byte_reg;
        endcase
    end

    assign nib_sel = cmd.use_table ? init_nibble(cmd.nib_idx)
                   : (cmd.nib_idx[0] ? byte_reg[3:0] : byte_reg[7:4]);

    always_comb
    begin
        snap_next.hold_ms = cmd.hold;
        snap_next.last    = cmd.last;
        unique case (cmd.kind)
            SNAP_PRE:
            begin
                snap_next.data_nibble = pin_nib_reg;
                snap_next.reg_select  = 1'b0;
                snap_next.enable_line = pin_en_reg;
            end
            SNAP_HI:
            begin
                snap_next.data_nibble = nib_sel;
                snap_next.reg_select  = cmd.rs;
                snap_next.enable_line = 1'b1;
            end
            SNAP_LO:
            begin
                snap_next.data_nibble = nib_sel;
                snap_next.reg_select  = cmd.rs;
                snap_next.enable_line = 1'b0;
            end
            SNAP_TAIL:
            begin
                snap_next.data_nibble = pin_nib_reg;
                snap_next.reg_select  = 1'b0;
                snap_next.enable_line = pin_en_reg;
            end
            default:
            begin
                snap_next.data_nibble = pin_nib_reg;
                snap_next.reg_select  = pin_rs_reg;
                snap_next.enable_line = pin_en_reg;
            end
        endcase
    end

    assign valid_next = cmd.emit | (valid_reg & snap_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pin_nib_reg <= 4'hF;
            pin_rs_reg  <= 1'b1;
            pin_en_reg  <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.emit)
            begin
                pin_nib_reg <= snap_next.data_nibble;
                pin_rs_reg  <= snap_next.reg_select;
                pin_en_reg  <= snap_next.enable_line;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= byte_next;
        end
        if (cmd.emit)
        begin
            snap_reg <= snap_next;
        end
    end

    assign status.out_free = !valid_reg || !snap_stall;
    assign snap_valid      = valid_reg;
    assign snap            = snap_reg;

endmodule

`default_nettype wire

// File: hw/rtl/char_lcd_nibble_sequencer_unit.sv
// Takes one request at a time (init, command byte, data character, cursor
// move, clear) and answers with a run of pin snapshots for a 4-bit character
// LCD bus, the final one flagged by last. After a request is taken the
// sequencer emits one snapshot per cycle while the output is not stalled:
// 24 snapshots for init, 4 for command and clear, 5 for data and cursor
// move. The rate is set by the single output register, which holds one
// snapshot at a time. Request codes 5 to 7 are taken and dropped without
// output. Pin levels persist between requests and start all high after
// reset.
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_unit
// Top level of the character LCD 4-bit nibble sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer_unit
    import lcd_seq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire lcd_req_t req,
    output logic          snap_valid,
    input  wire logic     snap_stall,
    output lcd_snap_t     snap
);

    lcd_cmd_t    cmd;
    lcd_status_t status;

    lcd_seq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lcd_seq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cmd        (cmd),
        .status     (status),
        .snap_valid (snap_valid),
        .snap_stall (snap_stall),
        .snap       (snap)
    );

endmodule

`default_nettype wire

// File: hw/rtl/lcd_seq_checker.sv
// ---------------------------------------------------------------------------
// lcd_seq_checker
// Port-level checks of the nibble sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcd_seq_checker
    import lcd_seq_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_stall,
    input wire lcd_req_t  req,
    input wire logic      snap_valid,
    input wire logic      snap_stall,
    input wire lcd_snap_t snap
);

    // stalled snapshot holds
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && snap_stall |=> snap_valid && $stable(snap))
        else $error("stalled snapshot changed");

    // an enable-high snapshot carries the strobe hold and is never the last
    a_strobe_hi: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && snap.enable_line |-> snap.hold_ms == HOLD_STROBE && !snap.last)
        else $error("enable high snapshot with wrong hold or last");

    // zero hold only on the closing snapshot of a data character
    a_tail: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && snap.hold_ms == HOLD_NONE
            |-> snap.last && !snap.reg_select && !snap.enable_line)
        else $error("zero hold snapshot malformed");

    // a taken request with a code from 0 to 4 keeps the block busy in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall
            && (req.req_type == REQ_INIT || req.req_type == REQ_CMD
                || req.req_type == REQ_DATA || req.req_type == REQ_CURSOR
                || req.req_type == REQ_CLEAR)
            |=> req_stall)
        else $error("request transaction not followed by busy");

endmodule

bind char_lcd_nibble_sequencer_unit lcd_seq_checker u_lcd_seq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .snap       (snap)
);

`default_nettype wire
